// ===== rtl/nef_pkg.sv =====
// Shared types, line symbols and the nibble classifier of the nibble escape frame encoder.
package nef_pkg;

  // Line symbols
  localparam logic [3:0] SYM_ZERO    = 4'h0;
  localparam logic [3:0] SYM_BEGIN   = 4'h5;
  localparam logic [3:0] SYM_END     = 4'h7;
  localparam logic [3:0] SYM_END_INV = ~SYM_END;
  localparam logic [3:0] SYM_ESC     = 4'hA;
  localparam logic [3:0] SYM_ESC2    = 4'hD;

  // Preamble register
  localparam logic [5:0] PREAMBLE_RESET = 6'd50;
  localparam logic [5:0] PREAMBLE_MAX   = 6'd56;

  // One data nibble as it goes on the line: optional prefix, then the symbol
  typedef struct packed {
    logic       pfx_en;
    logic [3:0] pfx;
    logic [3:0] sym;
  } nib_code_t;

  // Classified request handed from the front to the back
  typedef struct packed {
    logic       first;
    logic [5:0] pre_len;
    nib_code_t  hi;
    nib_code_t  lo;
    logic       last;
    logic       end_pfx_en;
    logic [3:0] end_sym;
  } cmd_t;

  // Back-end sequencer phases
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRE,
    ST_BEGIN,
    ST_HI_PFX,
    ST_HI,
    ST_LO_PFX,
    ST_LO,
    ST_END_PFX,
    ST_END
  } phase_t;

  // Queue status
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // Back-end status
  typedef struct packed {
    logic pop;
    logic busy;
  } bk_stat_t;

  // Escape rules for one nibble against the nibble sent before it
  function automatic nib_code_t encode_nibble(input logic [3:0] v, input logic [3:0] prev);
    nib_code_t  c;
    logic [3:0] inv;
    inv      = ~v;
    c.pfx_en = 1'b0;
    c.pfx    = SYM_ESC;
    c.sym    = v;
    if (v == SYM_ESC || v == SYM_END) begin
      c.pfx_en = 1'b1;
      c.pfx    = SYM_ESC2;
    end else if (v == SYM_ESC2 || v == prev) begin
      c.pfx_en = 1'b1;
      if (inv == SYM_ESC) begin
        // inverting would hit ESC: send as is behind ESC2
        c.pfx = SYM_ESC2;
      end else begin
        c.pfx = SYM_ESC;
        c.sym = inv;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/nef_in_if.sv =====
// Byte request channel of the nibble escape frame encoder.
interface nef_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_of_frame;
  logic       last_of_frame;

  modport source (output valid, output data_byte, output first_of_frame,
                  output last_of_frame, input ready);
  modport sink   (input valid, input data_byte, input first_of_frame,
                  input last_of_frame, output ready);
endinterface

// ===== rtl/nef_out_if.sv =====
// Nibble result channel of the nibble escape frame encoder.
interface nef_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] nibble;
  logic       end_of_run;

  modport source (output valid, output nibble, output end_of_run, input ready);
  modport sink   (input valid, input nibble, input end_of_run, output ready);
endinterface

// ===== rtl/nef_front.sv =====
// Front end: takes byte requests, tracks the previous nibble and classifies escapes.
module nef_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [5:0]       cfg_data,
  nef_in_if.sink           in_ch,
  input  nef_pkg::q_stat_t q_stat,
  output logic             push,
  output nef_pkg::cmd_t    cmd
);

  logic [5:0] preamble_r;
  logic [3:0] prev_r, prev_nxt;
  logic [3:0] prev_hi;
  logic [5:0] pre_len;

  // Preamble length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      preamble_r <= nef_pkg::PREAMBLE_RESET;
    end else if (cfg_we) begin
      preamble_r <= cfg_data;
    end
  end

  // Accept whenever the queue has room
  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && in_ch.ready;

  // Classification
  assign pre_len = (preamble_r > nef_pkg::PREAMBLE_MAX) ? nef_pkg::PREAMBLE_MAX : preamble_r;
  assign prev_hi = in_ch.first_of_frame ? nef_pkg::SYM_BEGIN : prev_r;

  always_comb begin
    cmd.first   = in_ch.first_of_frame;
    cmd.pre_len = pre_len;
    cmd.hi      = nef_pkg::encode_nibble(in_ch.data_byte[7:4], prev_hi);
    cmd.lo      = nef_pkg::encode_nibble(in_ch.data_byte[3:0], cmd.hi.sym);
    cmd.last    = in_ch.last_of_frame;
    // low nibble sent as END: close with ESC and inverted END
    cmd.end_pfx_en = (cmd.lo.sym == nef_pkg::SYM_END);
    cmd.end_sym    = cmd.end_pfx_en ? nef_pkg::SYM_END_INV : nef_pkg::SYM_END;
  end

  // Previous nibble as sent on the line; end marker leaves it alone
  assign prev_nxt = push ? cmd.lo.sym : prev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= nef_pkg::SYM_BEGIN;
    end else begin
      prev_r <= prev_nxt;
    end
  end

endmodule

// ===== rtl/nef_queue.sv =====
// Short request queue between the front end and the back end.
module nef_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  nef_pkg::cmd_t     wr_cmd,
  input  logic              pop,
  output nef_pkg::cmd_t     head,
  output nef_pkg::q_stat_t  q_stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  nef_pkg::cmd_t  entry_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == FULL_CNT);
  assign head         = entry_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

// ===== rtl/nef_back.sv =====
// Back end: walks each queued request and sends one nibble a cycle while out_ch is ready.
module nef_back (
  input  logic              clk,
  input  logic              rst_n,
  input  nef_pkg::cmd_t     head,
  input  nef_pkg::q_stat_t  q_stat,
  output nef_pkg::bk_stat_t bk_stat,
  nef_out_if.source         out_ch
);

  nef_pkg::phase_t state_r, state_nxt, cur;
  logic [5:0]      cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [3:0]      nibble_r, nibble_nxt;
  logic            eor_r, eor_nxt;
  logic            load_ok, emit;
  logic [3:0]      sym;
  logic            done;

  // First phase of a fresh request
  function automatic nef_pkg::phase_t start_phase(input nef_pkg::cmd_t c);
    if (c.first) begin
      return (c.pre_len == '0) ? nef_pkg::ST_BEGIN : nef_pkg::ST_PRE;
    end
    return c.hi.pfx_en ? nef_pkg::ST_HI_PFX : nef_pkg::ST_HI;
  endfunction

  assign cur     = (state_r == nef_pkg::ST_IDLE) ? start_phase(head) : state_r;
  assign load_ok = !out_valid_r || out_ch.ready;
  assign emit    = !q_stat.empty && load_ok;

  assign bk_stat.pop  = emit && done;
  assign bk_stat.busy = (state_r != nef_pkg::ST_IDLE);

  // Next phase
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    if (emit) begin
      unique case (cur)
        nef_pkg::ST_PRE: begin
          if (cnt_r + 6'd1 == head.pre_len) begin
            state_nxt = nef_pkg::ST_BEGIN;
            cnt_nxt   = '0;
          end else begin
            state_nxt = nef_pkg::ST_PRE;
            cnt_nxt   = cnt_r + 6'd1;
          end
        end
        nef_pkg::ST_BEGIN: begin
          state_nxt = head.hi.pfx_en ? nef_pkg::ST_HI_PFX : nef_pkg::ST_HI;
        end
        nef_pkg::ST_HI_PFX: state_nxt = nef_pkg::ST_HI;
        nef_pkg::ST_HI: begin
          state_nxt = head.lo.pfx_en ? nef_pkg::ST_LO_PFX : nef_pkg::ST_LO;
        end
        nef_pkg::ST_LO_PFX: state_nxt = nef_pkg::ST_LO;
        nef_pkg::ST_LO: begin
          if (!head.last) begin
            state_nxt = nef_pkg::ST_IDLE;
          end else begin
            state_nxt = head.end_pfx_en ? nef_pkg::ST_END_PFX : nef_pkg::ST_END;
          end
        end
        nef_pkg::ST_END_PFX: state_nxt = nef_pkg::ST_END;
        nef_pkg::ST_END:     state_nxt = nef_pkg::ST_IDLE;
        default:             state_nxt = nef_pkg::ST_IDLE;
      endcase
    end
  end

  // Symbol of the current phase
  always_comb begin
    sym  = nef_pkg::SYM_ZERO;
    done = 1'b0;
    unique case (cur)
      nef_pkg::ST_PRE:     sym = nef_pkg::SYM_ZERO;
      nef_pkg::ST_BEGIN:   sym = nef_pkg::SYM_BEGIN;
      nef_pkg::ST_HI_PFX:  sym = head.hi.pfx;
      nef_pkg::ST_HI:      sym = head.hi.sym;
      nef_pkg::ST_LO_PFX:  sym = head.lo.pfx;
      nef_pkg::ST_LO: begin
        sym  = head.lo.sym;
        done = !head.last;
      end
      nef_pkg::ST_END_PFX: sym = nef_pkg::SYM_ESC;
      nef_pkg::ST_END: begin
        sym  = head.end_sym;
        done = 1'b1;
      end
      default: begin
        sym  = nef_pkg::SYM_ZERO;
        done = 1'b0;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    nibble_nxt    = nibble_r;
    eor_nxt       = eor_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      nibble_nxt    = sym;
      eor_nxt       = done;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nef_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nibble_r <= nibble_nxt;
    eor_r    <= eor_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.nibble     = nibble_r;
  assign out_ch.end_of_run = eor_r;

endmodule

// ===== rtl/nibble_escape_frame_encoder.sv =====
// Top level of the nibble escape frame encoder.
//
// Byte requests come in on in_ch (data_byte, first_of_frame, last_of_frame) with a
// valid/ready handshake; encoded nibbles leave on out_ch, one per cycle while out_ch
// is ready, and end_of_run marks the last nibble caused by a byte. cfg_we/cfg_data
// write the preamble length (values above 56 act as 56); write it while the block is idle.
// The first nibble of a byte passes the queue entry and the output register before
// it is valid. The back-end sequencer sends a byte as 2 to 4 data nibbles, plus 1
// or 2 for the end marker on a frame's last byte, plus preamble_length zeros and
// BEGIN on a frame's first byte. The front end classifies a byte in the cycle it
// arrives and parks it in a QUEUE_DEPTH entry queue, so in_ch keeps taking bytes
// while the back end still sends earlier ones.
// Reset: queue empty, previous nibble BEGIN, preamble length 50; no clearing pass.
// Stalls: a low out_ch.ready holds the output register; the back end and then the
// queue fill, and in_ch.ready drops only once the queue is full.
module nibble_escape_frame_encoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [5:0] cfg_data,
  nef_in_if.sink     in_ch,
  nef_out_if.source  out_ch
);

  nef_pkg::cmd_t     wr_cmd;
  nef_pkg::cmd_t     head;
  nef_pkg::q_stat_t  q_stat;
  nef_pkg::bk_stat_t bk_stat;
  logic              push;

  nef_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .push     (push),
    .cmd      (wr_cmd)
  );

  nef_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (bk_stat.pop),
    .head   (head),
    .q_stat (q_stat)
  );

  nef_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_stat  (q_stat),
    .bk_stat (bk_stat),
    .out_ch  (out_ch)
  );

  // Queue never written when full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("request queue written while full");

  // Queue never popped when empty
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.pop |-> !q_stat.empty)
    else $error("request queue popped while empty");

  // A request in progress stays at the queue head
  a_busy_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.busy |-> !q_stat.empty)
    else $error("back end busy with no queued request");

  // A retired request leaves its end-of-run nibble in the output register
  a_pop_marks_end: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.pop |=> out_ch.valid && out_ch.end_of_run)
    else $error("request retired without an end-of-run nibble");

endmodule
